// File: src/pba_pkg.sv
package pba_pkg;

   localparam int WORD_COUNT    = 32768;
   localparam int BITS_PER_WORD = 32;

   localparam int WORD_AW     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W       = $clog2(BITS_PER_WORD);
   localparam int CMD_W       = 3;
   localparam int PAGE_W      = 20;
   localparam int WIDX_W      = 15;
   localparam int VALUE_W     = 32;

   localparam longint TOTAL_PAGES = longint'(WORD_COUNT) * longint'(BITS_PER_WORD);
   localparam longint PAGE_LIMIT  = longint'(1) << PAGE_W;
   localparam int     LIMIT_WORDS = int'(PAGE_LIMIT / BITS_PER_WORD);
   localparam int     SCAN_WORDS  = (WORD_COUNT < LIMIT_WORDS) ? WORD_COUNT : LIMIT_WORDS;

   typedef enum logic [CMD_W-1:0] {
      CMD_MARK_USED = 3'd0,
      CMD_MARK_FREE = 3'd1,
      CMD_QUERY     = 3'd2,
      CMD_ALLOCATE  = 3'd3,
      CMD_READ_WORD = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCAN
   } state_type;

endpackage

// File: src/pba_req_if.sv
interface pba_req_if import pba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [PAGE_W-1:0] page_index;
   logic [WIDX_W-1:0] word_index;

   modport source (output valid, output command, output page_index, output word_index,
                   input ready);
   modport sink   (input valid, input command, input page_index, input word_index,
                   output ready);
endinterface

// File: src/pba_rsp_if.sv
interface pba_rsp_if import pba_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               page_in_use;
   logic               page_found;
   logic [PAGE_W-1:0]  page_number;
   logic [VALUE_W-1:0] word_value;

   modport source (output valid, output page_in_use, output page_found,
                   output page_number, output word_value, input ready);
   modport sink   (input valid, input page_in_use, input page_found,
                   input page_number, input word_value, output ready);
endinterface

// File: src/page_bitmap_allocator_core.sv
// Channel    Direction  Word contents
// req_chan   in         command, page_index, word_index
// rsp_chan   out        page_in_use, page_found, page_number, word_value
//
// After reset the bitmap memory is cleared one word per cycle, all WORD_COUNT
// words (32768 by default); no word is accepted during that pass.
// Mark, free, query and read first read the memory word; mark and free then write it back.
// Allocate reads one word per cycle from word 0 and stops at the first word with
// a clear bit, after at most SCAN_WORDS words.
// A finished result waits in the output register; a stalled output holds the
// block in its last cycle until the register frees up.
module page_bitmap_allocator_core import pba_pkg::*; (
   input logic      clock,
   input logic      reset,
   pba_req_if.sink  req_chan,
   pba_rsp_if.source rsp_chan
);

   logic [BITS_PER_WORD-1:0] bitmap_mem [WORD_COUNT];
   logic [BITS_PER_WORD-1:0] rd_data_ff;

   state_type state_ff, state_in;
   logic [WORD_AW-1:0] clear_addr_ff, clear_addr_in;
   logic [WORD_AW-1:0] scan_addr_ff, scan_addr_in;
   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [WIDX_W-1:0]  widx_ff, widx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_in_use_ff, rsp_in_use_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [PAGE_W-1:0]  rsp_number_ff, rsp_number_in;
   logic [VALUE_W-1:0] rsp_value_ff, rsp_value_in;

   logic                     rd_en, wr_en;
   logic [WORD_AW-1:0]       rd_addr, wr_addr;
   logic [BITS_PER_WORD-1:0] wr_data;
   logic                     load_rsp;

   logic                     accept, out_free, page_ok, word_full, last_word;
   logic [WORD_AW-1:0]       page_word, req_page_word;
   logic [BIT_W-1:0]         page_bit, free_bit;
   logic [BITS_PER_WORD-1:0] page_mask, free_mask;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_page_word = WORD_AW'(req_chan.page_index >> BIT_W);
   assign page_word     = WORD_AW'(page_ff >> BIT_W);
   assign page_bit      = page_ff[BIT_W-1:0];
   assign page_mask     = {{(BITS_PER_WORD-1){1'b0}}, 1'b1} << page_bit;
   assign page_ok       = longint'(page_ff) < TOTAL_PAGES;

   assign word_full = &rd_data_ff;
   assign last_word = scan_addr_ff == WORD_AW'(SCAN_WORDS - 1);
   assign free_mask = {{(BITS_PER_WORD-1){1'b0}}, 1'b1} << free_bit;

   always_comb begin
      free_bit = '0;
      for (int b = BITS_PER_WORD - 1; b >= 0; b--) begin
         if (!rd_data_ff[b]) begin
            free_bit = BIT_W'(b);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == WORD_AW'(WORD_COUNT - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = (cmd_type'(req_chan.command) == CMD_ALLOCATE) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if ((!word_full || last_word) && out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      rd_en          = 1'b0;
      rd_addr        = '0;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      load_rsp       = 1'b0;
      clear_addr_in  = clear_addr_ff;
      scan_addr_in   = scan_addr_ff;
      cmd_in         = cmd_ff;
      page_in        = page_ff;
      widx_in        = widx_ff;
      rsp_in_use_in  = 1'b0;
      rsp_found_in   = 1'b0;
      rsp_number_in  = '0;
      rsp_value_in   = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            clear_addr_in = clear_addr_ff + WORD_AW'(1);
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (accept) begin
               rd_en        = 1'b1;
               cmd_in       = req_chan.command;
               page_in      = req_chan.page_index;
               widx_in      = req_chan.word_index;
               scan_addr_in = '0;
               case (cmd_type'(req_chan.command))
                  CMD_ALLOCATE:  rd_addr = '0;
                  CMD_READ_WORD: rd_addr = WORD_AW'(req_chan.word_index);
                  default:       rd_addr = req_page_word;
               endcase
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               load_rsp = 1'b1;
               wr_addr  = page_word;
               case (cmd_type'(cmd_ff))
                  CMD_MARK_USED: begin
                     wr_en   = page_ok;
                     wr_data = rd_data_ff | page_mask;
                  end
                  CMD_MARK_FREE: begin
                     wr_en   = page_ok;
                     wr_data = rd_data_ff & ~page_mask;
                  end
                  CMD_QUERY: begin
                     rsp_in_use_in = page_ok && ((rd_data_ff & page_mask) != '0);
                  end
                  CMD_READ_WORD: begin
                     if (int'(widx_ff) < WORD_COUNT) begin
                        rsp_value_in = VALUE_W'(rd_data_ff);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (!word_full) begin
               if (out_free) begin
                  load_rsp      = 1'b1;
                  wr_en         = 1'b1;
                  wr_addr       = scan_addr_ff;
                  wr_data       = rd_data_ff | free_mask;
                  rsp_found_in  = 1'b1;
                  rsp_number_in = PAGE_W'({scan_addr_ff, free_bit});
               end
            end else if (last_word) begin
               load_rsp = out_free;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = scan_addr_ff + WORD_AW'(1);
               scan_addr_in = scan_addr_ff + WORD_AW'(1);
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= bitmap_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      cmd_ff       <= cmd_in;
      page_ff      <= page_in;
      widx_ff      <= widx_in;
      if (load_rsp) begin
         rsp_in_use_ff <= rsp_in_use_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_number_ff <= rsp_number_in;
         rsp_value_ff  <= rsp_value_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.page_in_use = rsp_in_use_ff;
   assign rsp_chan.page_found  = rsp_found_ff;
   assign rsp_chan.page_number = rsp_number_ff;
   assign rsp_chan.word_value  = rsp_value_ff;

endmodule

// File: bench/page_bitmap_allocator_core_tb.sv
module page_bitmap_allocator_core_tb;
   import pba_pkg::*;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int DIRECTED_ROWS = 25;
   localparam int HOLD_CYCLES   = 150;
   localparam int SETTLE_CYCLES = 64;
   localparam int LOW_PAGES     = 384;

   localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

   typedef struct packed {
      logic               in_use;
      logic               found;
      logic [PAGE_W-1:0]  number;
      logic [VALUE_W-1:0] value;
   } bitmap_result_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [PAGE_W-1:0] page;
      logic [WIDX_W-1:0] widx;
      logic              typed;
      bitmap_result_type result;
   } stimulus_row_type;

   logic clock = 1'b0;
   logic reset;

   pba_req_if req_bus ();
   pba_rsp_if rsp_bus ();

   page_bitmap_allocator_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   logic [BITS_PER_WORD-1:0] predicted_bitmap [WORD_COUNT];
   bitmap_result_type        awaited_results [$];
   bitmap_result_type        oldest_result;

   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   bit          hold_off_request;
   int unsigned hold_off_left;
   int unsigned cycle_count;
   int unsigned error_count;
   int unsigned words_sent;
   int unsigned results_checked;
   int unsigned allocations_taken;
   int unsigned deepest_alloc_word;
   int unsigned input_stall_cycles;

   // Query and read rows after reset, extremes and the reserved commands carry
   // their result here; the rest are left to the predictor.
   stimulus_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_QUERY,     20'd0,       15'd0,      1'b1, '0},
      '{CMD_READ_WORD, 20'd0,       15'd0,      1'b1, '0},
      '{CMD_ALLOCATE,  20'hFFFFF,   15'h7FFF,   1'b1, '{1'b0, 1'b1, 20'd0, 32'd0}},
      '{CMD_QUERY,     20'd0,       15'd0,      1'b1, '{1'b1, 1'b0, 20'd0, 32'd0}},
      '{CMD_READ_WORD, 20'd0,       15'd0,      1'b1, '{1'b0, 1'b0, 20'd0, 32'd1}},
      '{CMD_MARK_USED, 20'hFFFFF,   15'd0,      1'b1, '0},
      '{CMD_QUERY,     20'hFFFFF,   15'd0,      1'b1, '{1'b1, 1'b0, 20'd0, 32'd0}},
      '{CMD_READ_WORD, 20'd0,       15'h7FFF,   1'b1, '{1'b0, 1'b0, 20'd0, 32'h8000_0000}},
      '{CMD_MARK_USED, 20'd31,      15'd0,      1'b0, '0},
      '{CMD_READ_WORD, 20'd0,       15'd0,      1'b0, '0},
      '{CMD_ALLOCATE,  20'd0,       15'd0,      1'b0, '0},
      '{CMD_MARK_FREE, 20'd0,       15'd0,      1'b0, '0},
      '{CMD_QUERY,     20'd0,       15'd0,      1'b0, '0},
      '{CMD_ALLOCATE,  20'd0,       15'd0,      1'b0, '0},
      '{CMD_MARK_FREE, 20'hFFFFF,   15'd0,      1'b1, '0},
      '{CMD_READ_WORD, 20'd0,       15'h7FFF,   1'b1, '0},
      '{CMD_MARK_FREE, 20'd5,       15'd0,      1'b0, '0},
      '{CMD_MARK_USED, 20'd1,       15'd0,      1'b0, '0},
      '{CMD_SPARE_7,   20'hFFFFF,   15'h7FFF,   1'b1, '0},
      '{CMD_SPARE_5,   20'd0,       15'd0,      1'b1, '0},
      '{CMD_SPARE_6,   20'h5A5A5,   15'h2A2A,   1'b1, '0},
      '{CMD_READ_WORD, 20'd0,       15'd0,      1'b0, '0},
      '{CMD_MARK_USED, 20'd32,      15'd0,      1'b0, '0},
      '{CMD_ALLOCATE,  20'hAAAAA,   15'h5555,   1'b0, '0},
      '{CMD_QUERY,     20'h55555,   15'd0,      1'b0, '0}
   };

   function automatic bitmap_result_type predict_command(input logic [CMD_W-1:0]  cmd,
                                                         input logic [PAGE_W-1:0] page,
                                                         input logic [WIDX_W-1:0] widx);
      bitmap_result_type result;
      int                word_sel;
      int                bit_sel;
      bit                page_ok;
      longint            page_no;
      int                w;
      int                b;
      result   = '0;
      word_sel = int'(page) / BITS_PER_WORD;
      bit_sel  = int'(page) % BITS_PER_WORD;
      page_ok  = longint'(page) < TOTAL_PAGES;
      case (cmd)
         CMD_MARK_USED: begin
            if (page_ok) predicted_bitmap[word_sel][bit_sel] = 1'b1;
         end
         CMD_MARK_FREE: begin
            if (page_ok) predicted_bitmap[word_sel][bit_sel] = 1'b0;
         end
         CMD_QUERY: begin
            if (page_ok) result.in_use = predicted_bitmap[word_sel][bit_sel];
         end
         CMD_ALLOCATE: begin
            // First fit: skip full words, then take the lowest clear bit whose
            // page number still fits in the result field.
            for (w = 0; w < WORD_COUNT && !result.found; w++) begin
               if (predicted_bitmap[w] != '1) begin
                  for (b = 0; b < BITS_PER_WORD; b++) begin
                     page_no = longint'(w) * BITS_PER_WORD + b;
                     if (page_no >= PAGE_LIMIT) break;
                     if (!predicted_bitmap[w][b]) begin
                        predicted_bitmap[w][b] = 1'b1;
                        result.found  = 1'b1;
                        result.number = PAGE_W'(page_no);
                        if (w > deepest_alloc_word) deepest_alloc_word = w;
                        allocations_taken++;
                        break;
                     end
                  end
                  if (!result.found && longint'(w + 1) * BITS_PER_WORD >= PAGE_LIMIT) break;
               end
            end
         end
         CMD_READ_WORD: begin
            if (int'(widx) < WORD_COUNT) result.value = VALUE_W'(predicted_bitmap[widx]);
         end
         default: begin
         end
      endcase
      return result;
   endfunction

   task automatic offer_word(input logic [CMD_W-1:0]  cmd,
                             input logic [PAGE_W-1:0] page,
                             input logic [WIDX_W-1:0] widx,
                             input logic              typed,
                             input bitmap_result_type typed_result);
      bitmap_result_type predicted;
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.page_index <= page;
      req_bus.word_index <= widx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predicted = predict_command(cmd, page, widx);
      awaited_results.push_back(typed ? typed_result : predicted);
      words_sent++;
   endtask

   function automatic logic [CMD_W-1:0] pick_spare_command();
      case ($urandom_range(2))
         0:       return CMD_SPARE_5;
         1:       return CMD_SPARE_6;
         default: return CMD_SPARE_7;
      endcase
   endfunction

   task automatic offer_random_word();
      int unsigned       pick;
      logic [CMD_W-1:0]  cmd;
      logic [PAGE_W-1:0] page;
      logic [WIDX_W-1:0] widx;
      pick = $urandom_range(99);
      page = PAGE_W'($urandom);
      widx = WIDX_W'($urandom);
      if (pick < 25) begin
         cmd = CMD_ALLOCATE;
      end else if (pick < 42) begin
         cmd  = CMD_MARK_USED;
         page = PAGE_W'($urandom_range(LOW_PAGES - 1));
      end else if (pick < 58) begin
         cmd  = CMD_MARK_FREE;
         page = PAGE_W'($urandom_range(LOW_PAGES - 1));
      end else if (pick < 70) begin
         cmd = CMD_QUERY;
         if ($urandom_range(1) == 0) page = PAGE_W'($urandom_range(LOW_PAGES - 1));
      end else if (pick < 82) begin
         cmd = CMD_READ_WORD;
         if ($urandom_range(4) != 0) widx = WIDX_W'($urandom_range(LOW_PAGES / BITS_PER_WORD));
      end else if (pick < 94) begin
         case ($urandom_range(2))
            0:       cmd = CMD_MARK_USED;
            1:       cmd = CMD_MARK_FREE;
            default: cmd = CMD_QUERY;
         endcase
      end else begin
         cmd = pick_spare_command();
      end
      offer_word(cmd, page, widx, 1'b0, '0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_off_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_off_left--;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_off_left    = HOLD_CYCLES;
         rsp_bus.ready   <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("page_bitmap_allocator_core_tb: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_bus.valid && !req_bus.ready) input_stall_cycles++;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_results.size() == 0) begin
            $error("result word with no command outstanding");
            error_count++;
         end else begin
            oldest_result = awaited_results.pop_front();
            if (rsp_bus.page_in_use !== oldest_result.in_use) begin
               $error("page_in_use: expected %0d, got %0d",
                      oldest_result.in_use, rsp_bus.page_in_use);
               error_count++;
            end
            if (rsp_bus.page_found !== oldest_result.found) begin
               $error("page_found: expected %0d, got %0d",
                      oldest_result.found, rsp_bus.page_found);
               error_count++;
            end
            if (rsp_bus.page_number !== oldest_result.number) begin
               $error("page_number: expected %0d, got %0d",
                      oldest_result.number, rsp_bus.page_number);
               error_count++;
            end
            if (rsp_bus.word_value !== oldest_result.value) begin
               $error("word_value: expected 0x%08h, got 0x%08h",
                      oldest_result.value, rsp_bus.word_value);
               error_count++;
            end
         end
         results_checked++;
      end
   end

   initial begin
      int row;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_MARK_USED;
      req_bus.page_index = '0;
      req_bus.word_index = '0;
      rsp_bus.ready      = 1'b0;
      sender_idle_pct    = 37;
      receiver_idle_pct  = 37;
      hold_off_request   = 1'b0;
      hold_off_left      = 0;
      cycle_count        = 0;
      error_count        = 0;
      words_sent         = 0;
      results_checked    = 0;
      allocations_taken  = 0;
      deepest_alloc_word = 0;
      input_stall_cycles = 0;
      foreach (predicted_bitmap[i]) predicted_bitmap[i] = '0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         offer_word(directed_rows[row].cmd, directed_rows[row].page, directed_rows[row].widx,
                    directed_rows[row].typed, directed_rows[row].result);
      end
      drain_results();

      repeat (300) offer_random_word();

      // The receiver stops taking result words while commands keep coming,
      // so the block must back up and hold off its input.
      sender_idle_pct  = 0;
      hold_off_request = 1'b1;
      repeat (40) offer_random_word();
      drain_results();

      receiver_idle_pct = 0;
      repeat (150) offer_random_word();

      sender_idle_pct   = 37;
      receiver_idle_pct = 37;
      repeat (185) offer_random_word();
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d command words and checked %0d result words; %0d pages allocated,",
               words_sent, results_checked, allocations_taken);
      $display("deepest allocation in bitmap word %0d, %0d cycles with the input held off.",
               deepest_alloc_word, input_stall_cycles);
      if (error_count == 0) begin
         $display("page_bitmap_allocator_core_tb: clean");
      end else begin
         $display("page_bitmap_allocator_core_tb: errors");
      end
      $finish;
   end

endmodule
